FILE: sv/orso_pkg.sv
// shared constants for the oriented rectangle overlap pipeline
// no dependencies; imported by orso_ext, orso_cmp and the top level

package orso_pkg;

    localparam int unsigned N_AXES        = 4;
    localparam int unsigned TERMS_PER_AXIS = 3;

    localparam int unsigned AX_A_RIGHT = 0;
    localparam int unsigned AX_A_UP    = 1;
    localparam int unsigned AX_B_RIGHT = 2;
    localparam int unsigned AX_B_UP    = 3;

    typedef logic [N_AXES-1:0] t_axis_mask;

endpackage

FILE: sv/orso_if.sv
// channel interfaces: rectangle pair in, overlap flag out
// no dependencies

interface orso_pair_if #(
    parameter int unsigned COORD_WIDTH   = 24,
    parameter int unsigned DIR_FRAC_BITS = 14
);
    logic                              valid;
    logic                              ready;
    logic signed [COORD_WIDTH-1:0]     a_pos_x;
    logic signed [COORD_WIDTH-1:0]     a_pos_y;
    logic signed [DIR_FRAC_BITS+1:0]   a_right_x;
    logic signed [DIR_FRAC_BITS+1:0]   a_right_y;
    logic        [COORD_WIDTH-1:0]     a_width;
    logic        [COORD_WIDTH-1:0]     a_height;
    logic signed [COORD_WIDTH-1:0]     b_pos_x;
    logic signed [COORD_WIDTH-1:0]     b_pos_y;
    logic signed [DIR_FRAC_BITS+1:0]   b_right_x;
    logic signed [DIR_FRAC_BITS+1:0]   b_right_y;
    logic        [COORD_WIDTH-1:0]     b_width;
    logic        [COORD_WIDTH-1:0]     b_height;

    modport source (
        output valid, a_pos_x, a_pos_y, a_right_x, a_right_y, a_width, a_height,
               b_pos_x, b_pos_y, b_right_x, b_right_y, b_width, b_height,
        input  ready
    );
    modport sink (
        input  valid, a_pos_x, a_pos_y, a_right_x, a_right_y, a_width, a_height,
               b_pos_x, b_pos_y, b_right_x, b_right_y, b_width, b_height,
        output ready
    );
endinterface

interface orso_res_if;
    logic valid;
    logic ready;
    logic overlap;

    modport source (output valid, overlap, input ready);
    modport sink (input valid, overlap, output ready);
endinterface

FILE: sv/orso_dot.sv
// stages 1-2: direction products, axis dot magnitudes, center delta projections
// no dependencies

module orso_dot #(
    parameter int unsigned CW = 24,
    parameter int unsigned F  = 14
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [CW-1:0]          i_a_pos_x,
    input  logic signed [CW-1:0]          i_a_pos_y,
    input  logic signed [F+1:0]           i_a_right_x,
    input  logic signed [F+1:0]           i_a_right_y,
    input  logic        [CW-1:0]          i_a_width,
    input  logic        [CW-1:0]          i_a_height,
    input  logic signed [CW-1:0]          i_b_pos_x,
    input  logic signed [CW-1:0]          i_b_pos_y,
    input  logic signed [F+1:0]           i_b_right_x,
    input  logic signed [F+1:0]           i_b_right_y,
    input  logic        [CW-1:0]          i_b_width,
    input  logic        [CW-1:0]          i_b_height,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic        [2*F+3:0]         o_aa,
    output logic        [2*F+3:0]         o_bb,
    output logic        [2*F+3:0]         o_c,
    output logic        [2*F+3:0]         o_s,
    output logic signed [F+CW+2:0]        o_p_ar0,
    output logic signed [F+CW+2:0]        o_p_ar1,
    output logic signed [F+CW+2:0]        o_p_au0,
    output logic signed [F+CW+2:0]        o_p_au1,
    output logic signed [F+CW+2:0]        o_p_br0,
    output logic signed [F+CW+2:0]        o_p_br1,
    output logic signed [F+CW+2:0]        o_p_bu0,
    output logic signed [F+CW+2:0]        o_p_bu1,
    output logic        [CW-1:0]          o_a_width,
    output logic        [CW-1:0]          o_a_height,
    output logic        [CW-1:0]          o_b_width,
    output logic        [CW-1:0]          o_b_height
);

    localparam int unsigned DW  = F + 2;
    localparam int unsigned PPW = 2 * DW;
    localparam int unsigned DXW = CW + 1;
    localparam int unsigned QW  = DW + DXW;

    logic en1, en2;
    logic r_v1, r_v2;

    // stage 1
    logic signed [PPW-1:0] r1_aa0, r1_aa1, r1_bb0, r1_bb1;
    logic signed [PPW-1:0] r1_c0, r1_c1, r1_s0, r1_s1;
    logic signed [DW-1:0]  r1_arx, r1_ary, r1_brx, r1_bry;
    logic signed [DXW-1:0] r1_dx, r1_dy;
    logic        [CW-1:0]  r1_aw, r1_ah, r1_bw, r1_bh;
    logic signed [DXW-1:0] n_dx, n_dy;

    // stage 2
    logic signed [PPW:0]   n_aa_s, n_bb_s, n_c_s, n_s_s;
    logic        [PPW:0]   n_aa, n_bb, n_c, n_s;
    logic        [PPW-1:0] r2_aa, r2_bb, r2_c, r2_s;
    logic signed [QW-1:0]  r2_ar0, r2_ar1, r2_au0, r2_au1;
    logic signed [QW-1:0]  r2_br0, r2_br1, r2_bu0, r2_bu1;
    logic        [CW-1:0]  r2_aw, r2_ah, r2_bw, r2_bh;

    assign en2     = !r_v2 || i_ready;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    assign n_dx = $signed({i_a_pos_x[CW-1], i_a_pos_x}) - $signed({i_b_pos_x[CW-1], i_b_pos_x});
    assign n_dy = $signed({i_a_pos_y[CW-1], i_a_pos_y}) - $signed({i_b_pos_y[CW-1], i_b_pos_y});

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_aa0 <= i_a_right_x * i_a_right_x;
            r1_aa1 <= i_a_right_y * i_a_right_y;
            r1_bb0 <= i_b_right_x * i_b_right_x;
            r1_bb1 <= i_b_right_y * i_b_right_y;
            r1_c0  <= i_a_right_x * i_b_right_x;
            r1_c1  <= i_a_right_y * i_b_right_y;
            r1_s0  <= i_a_right_x * i_b_right_y;
            r1_s1  <= i_a_right_y * i_b_right_x;
            r1_arx <= i_a_right_x;
            r1_ary <= i_a_right_y;
            r1_brx <= i_b_right_x;
            r1_bry <= i_b_right_y;
            r1_dx  <= n_dx;
            r1_dy  <= n_dy;
            r1_aw  <= i_a_width;
            r1_ah  <= i_a_height;
            r1_bw  <= i_b_width;
            r1_bh  <= i_b_height;
        end
    end

    // right.right equals up.up, right.up is zero, cross terms pair up
    always_comb begin
        n_aa_s = $signed({r1_aa0[PPW-1], r1_aa0}) + $signed({r1_aa1[PPW-1], r1_aa1});
        n_bb_s = $signed({r1_bb0[PPW-1], r1_bb0}) + $signed({r1_bb1[PPW-1], r1_bb1});
        n_c_s  = $signed({r1_c0[PPW-1], r1_c0}) + $signed({r1_c1[PPW-1], r1_c1});
        n_s_s  = $signed({r1_s0[PPW-1], r1_s0}) - $signed({r1_s1[PPW-1], r1_s1});
        n_aa   = n_aa_s[PPW] ? -n_aa_s : n_aa_s;
        n_bb   = n_bb_s[PPW] ? -n_bb_s : n_bb_s;
        n_c    = n_c_s[PPW] ? -n_c_s : n_c_s;
        n_s    = n_s_s[PPW] ? -n_s_s : n_s_s;
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_aa  <= n_aa[PPW-1:0];
            r2_bb  <= n_bb[PPW-1:0];
            r2_c   <= n_c[PPW-1:0];
            r2_s   <= n_s[PPW-1:0];
            r2_ar0 <= r1_arx * r1_dx;
            r2_ar1 <= r1_ary * r1_dy;
            r2_au0 <= r1_ary * r1_dx;
            r2_au1 <= r1_arx * r1_dy;
            r2_br0 <= r1_brx * r1_dx;
            r2_br1 <= r1_bry * r1_dy;
            r2_bu0 <= r1_bry * r1_dx;
            r2_bu1 <= r1_brx * r1_dy;
            r2_aw  <= r1_aw;
            r2_ah  <= r1_ah;
            r2_bw  <= r1_bw;
            r2_bh  <= r1_bh;
        end
    end

    assign o_aa       = r2_aa;
    assign o_bb       = r2_bb;
    assign o_c        = r2_c;
    assign o_s        = r2_s;
    assign o_p_ar0    = r2_ar0;
    assign o_p_ar1    = r2_ar1;
    assign o_p_au0    = r2_au0;
    assign o_p_au1    = r2_au1;
    assign o_p_br0    = r2_br0;
    assign o_p_br1    = r2_br1;
    assign o_p_bu0    = r2_bu0;
    assign o_p_bu1    = r2_bu1;
    assign o_a_width  = r2_aw;
    assign o_a_height = r2_ah;
    assign o_b_width  = r2_bw;
    assign o_b_height = r2_bh;

endmodule

FILE: sv/orso_ext.sv
// stages 3-4: projected half-extent terms and sums, center projection magnitudes
// depends on orso_pkg

module orso_ext #(
    parameter int unsigned CW = 24,
    parameter int unsigned F  = 14
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    output logic                                          o_ready,
    input  logic        [2*F+3:0]                         i_aa,
    input  logic        [2*F+3:0]                         i_bb,
    input  logic        [2*F+3:0]                         i_c,
    input  logic        [2*F+3:0]                         i_s,
    input  logic signed [F+CW+2:0]                        i_p_ar0,
    input  logic signed [F+CW+2:0]                        i_p_ar1,
    input  logic signed [F+CW+2:0]                        i_p_au0,
    input  logic signed [F+CW+2:0]                        i_p_au1,
    input  logic signed [F+CW+2:0]                        i_p_br0,
    input  logic signed [F+CW+2:0]                        i_p_br1,
    input  logic signed [F+CW+2:0]                        i_p_bu0,
    input  logic signed [F+CW+2:0]                        i_p_bu1,
    input  logic        [CW-1:0]                          i_a_width,
    input  logic        [CW-1:0]                          i_a_height,
    input  logic        [CW-1:0]                          i_b_width,
    input  logic        [CW-1:0]                          i_b_height,
    output logic                                          o_valid,
    input  logic                                          i_ready,
    output logic [orso_pkg::N_AXES-1:0][2*F+CW+5:0]       o_ext,
    output logic [orso_pkg::N_AXES-1:0][F+CW+2:0]         o_proj
);
    import orso_pkg::*;

    localparam int unsigned MW = 2 * F + 4;
    localparam int unsigned QW = F + CW + 3;
    localparam int unsigned XW = MW + CW;
    localparam int unsigned SW = XW + 2;

    logic en3, en4;
    logic r_v3, r_v4;

    logic signed [N_AXES-1:0][QW:0]                      n_ps;
    logic        [N_AXES-1:0][QW:0]                      n_pa;
    logic [N_AXES-1:0][TERMS_PER_AXIS-1:0][XW-1:0]       r3_t;
    logic [N_AXES-1:0][QW-1:0]                           r3_pj;
    logic [N_AXES-1:0][SW-1:0]                           r4_ext;
    logic [N_AXES-1:0][QW-1:0]                           r4_pj;

    assign en4     = !r_v4 || i_ready;
    assign en3     = !r_v3 || en4;
    assign o_ready = en3;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en3) begin
                r_v3 <= i_valid;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_comb begin
        n_ps[AX_A_RIGHT] = $signed({i_p_ar0[QW-1], i_p_ar0}) + $signed({i_p_ar1[QW-1], i_p_ar1});
        n_ps[AX_A_UP]    = $signed({i_p_au1[QW-1], i_p_au1}) - $signed({i_p_au0[QW-1], i_p_au0});
        n_ps[AX_B_RIGHT] = $signed({i_p_br0[QW-1], i_p_br0}) + $signed({i_p_br1[QW-1], i_p_br1});
        n_ps[AX_B_UP]    = $signed({i_p_bu1[QW-1], i_p_bu1}) - $signed({i_p_bu0[QW-1], i_p_bu0});
        for (int k = 0; k < N_AXES; k++) begin
            n_pa[k] = n_ps[k][QW] ? -n_ps[k] : n_ps[k];
        end
    end

    // zero terms (right against own up) are left out
    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_t[AX_A_RIGHT][0] <= XW'(i_aa) * XW'(i_a_width);
            r3_t[AX_A_RIGHT][1] <= XW'(i_c)  * XW'(i_b_width);
            r3_t[AX_A_RIGHT][2] <= XW'(i_s)  * XW'(i_b_height);
            r3_t[AX_A_UP][0]    <= XW'(i_aa) * XW'(i_a_height);
            r3_t[AX_A_UP][1]    <= XW'(i_s)  * XW'(i_b_width);
            r3_t[AX_A_UP][2]    <= XW'(i_c)  * XW'(i_b_height);
            r3_t[AX_B_RIGHT][0] <= XW'(i_c)  * XW'(i_a_width);
            r3_t[AX_B_RIGHT][1] <= XW'(i_s)  * XW'(i_a_height);
            r3_t[AX_B_RIGHT][2] <= XW'(i_bb) * XW'(i_b_width);
            r3_t[AX_B_UP][0]    <= XW'(i_s)  * XW'(i_a_width);
            r3_t[AX_B_UP][1]    <= XW'(i_c)  * XW'(i_a_height);
            r3_t[AX_B_UP][2]    <= XW'(i_bb) * XW'(i_b_height);
            for (int k = 0; k < N_AXES; k++) begin
                r3_pj[k] <= n_pa[k][QW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            for (int k = 0; k < N_AXES; k++) begin
                r4_ext[k] <= SW'(r3_t[k][0]) + SW'(r3_t[k][1]) + SW'(r3_t[k][2]);
                r4_pj[k]  <= r3_pj[k];
            end
        end
    end

    assign o_ext  = r4_ext;
    assign o_proj = r4_pj;

endmodule

FILE: sv/orso_cmp.sv
// stage 5: per-axis separation compare and overlap flag register
// depends on orso_pkg

module orso_cmp #(
    parameter int unsigned CW = 24,
    parameter int unsigned F  = 14
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic [orso_pkg::N_AXES-1:0][2*F+CW+5:0]  i_ext,
    input  logic [orso_pkg::N_AXES-1:0][F+CW+2:0]    i_proj,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic                                     o_overlap
);
    import orso_pkg::*;

    localparam int unsigned SW   = 2 * F + CW + 6;
    localparam int unsigned PW   = F + CW + 3;
    localparam int unsigned CMPW = (SW > PW + F + 1) ? SW : PW + F + 1;

    logic       en5;
    logic       r_v5;
    logic       r5_overlap;
    t_axis_mask n_sep;

    assign en5     = !r_v5 || i_ready;
    assign o_ready = en5;
    assign o_valid = r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (en5) begin
            r_v5 <= i_valid;
        end
    end

    // half sizes are folded into the scale of the center projection
    always_comb begin
        for (int k = 0; k < N_AXES; k++) begin
            n_sep[k] = CMPW'(i_ext[k]) < (CMPW'(i_proj[k]) << (F + 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_overlap <= ~|n_sep;
        end
    end

    assign o_overlap = r5_overlap;

endmodule

FILE: sv/oriented_rect_overlap_sat.sv
// top level of the oriented rectangle overlap test
// depends on orso_pkg, orso_if, orso_dot, orso_ext, orso_cmp

// Separating axis overlap test for two oriented rectangles, fully pipelined:
// one rectangle pair is accepted every clock cycle and its overlap flag comes
// out through the stages (direction products, dot/projection products, extent
// products, extent sums, compare), with stalls from the result side pushed
// back stage by stage so no transfer is lost or repeated. Each rectangle's up
// axis is its right axis turned 90 degrees. Directions are used exactly as
// given (no renormalization); touching rectangles count as overlapping.

module oriented_rect_overlap_sat #(
    parameter int unsigned COORD_WIDTH   = 24,
    parameter int unsigned DIR_FRAC_BITS = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    orso_pair_if.sink   i_pair,
    orso_res_if.source  o_res
);
    import orso_pkg::*;

    localparam int unsigned CW = COORD_WIDTH;
    localparam int unsigned F  = DIR_FRAC_BITS;

    logic                          dot_valid, dot_ready;
    logic        [2*F+3:0]         dot_aa, dot_bb, dot_c, dot_s;
    logic signed [F+CW+2:0]        dot_ar0, dot_ar1, dot_au0, dot_au1;
    logic signed [F+CW+2:0]        dot_br0, dot_br1, dot_bu0, dot_bu1;
    logic        [CW-1:0]          dot_aw, dot_ah, dot_bw, dot_bh;

    logic                              ext_valid, ext_ready;
    logic [N_AXES-1:0][2*F+CW+5:0]     ext_sum;
    logic [N_AXES-1:0][F+CW+2:0]       ext_proj;

    orso_dot #(.CW(CW), .F(F)) u_dot (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_pair.valid),
        .o_ready     (i_pair.ready),
        .i_a_pos_x   (i_pair.a_pos_x),
        .i_a_pos_y   (i_pair.a_pos_y),
        .i_a_right_x (i_pair.a_right_x),
        .i_a_right_y (i_pair.a_right_y),
        .i_a_width   (i_pair.a_width),
        .i_a_height  (i_pair.a_height),
        .i_b_pos_x   (i_pair.b_pos_x),
        .i_b_pos_y   (i_pair.b_pos_y),
        .i_b_right_x (i_pair.b_right_x),
        .i_b_right_y (i_pair.b_right_y),
        .i_b_width   (i_pair.b_width),
        .i_b_height  (i_pair.b_height),
        .o_valid     (dot_valid),
        .i_ready     (dot_ready),
        .o_aa        (dot_aa),
        .o_bb        (dot_bb),
        .o_c         (dot_c),
        .o_s         (dot_s),
        .o_p_ar0     (dot_ar0),
        .o_p_ar1     (dot_ar1),
        .o_p_au0     (dot_au0),
        .o_p_au1     (dot_au1),
        .o_p_br0     (dot_br0),
        .o_p_br1     (dot_br1),
        .o_p_bu0     (dot_bu0),
        .o_p_bu1     (dot_bu1),
        .o_a_width   (dot_aw),
        .o_a_height  (dot_ah),
        .o_b_width   (dot_bw),
        .o_b_height  (dot_bh)
    );

    orso_ext #(.CW(CW), .F(F)) u_ext (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (dot_valid),
        .o_ready    (dot_ready),
        .i_aa       (dot_aa),
        .i_bb       (dot_bb),
        .i_c        (dot_c),
        .i_s        (dot_s),
        .i_p_ar0    (dot_ar0),
        .i_p_ar1    (dot_ar1),
        .i_p_au0    (dot_au0),
        .i_p_au1    (dot_au1),
        .i_p_br0    (dot_br0),
        .i_p_br1    (dot_br1),
        .i_p_bu0    (dot_bu0),
        .i_p_bu1    (dot_bu1),
        .i_a_width  (dot_aw),
        .i_a_height (dot_ah),
        .i_b_width  (dot_bw),
        .i_b_height (dot_bh),
        .o_valid    (ext_valid),
        .i_ready    (ext_ready),
        .o_ext      (ext_sum),
        .o_proj     (ext_proj)
    );

    orso_cmp #(.CW(CW), .F(F)) u_cmp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (ext_valid),
        .o_ready   (ext_ready),
        .i_ext     (ext_sum),
        .i_proj    (ext_proj),
        .o_valid   (o_res.valid),
        .i_ready   (o_res.ready),
        .o_overlap (o_res.overlap)
    );

endmodule

FILE: tb/sv/tb_oriented_rect_overlap_sat.sv
// self-checking testbench for oriented_rect_overlap_sat: separating axis overlap flags
// depends on orso_pkg, orso_if and the rtl of the block; random stalls on both channels

module tb_oriented_rect_overlap_sat;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned COORD_W  = 24;
    localparam int unsigned DIR_FRAC = 14;
    localparam int unsigned DIR_W    = DIR_FRAC + 2;
    localparam int          PREDICT  = -1;
    localparam int          N_RANDOM = 880;
    localparam int          N_QUIET  = 150;
    localparam int          HOLD_AT  = 200;
    localparam int          PAUSE_AT = 500;
    localparam int          HOLD_CYCLES = 80;
    localparam int          DRAIN_CYCLES = 20;

    typedef struct packed {
        logic signed [COORD_W-1:0]    a_pos_x;
        logic signed [COORD_W-1:0]    a_pos_y;
        logic signed [DIR_FRAC+1:0]   a_right_x;
        logic signed [DIR_FRAC+1:0]   a_right_y;
        logic        [COORD_W-1:0]    a_width;
        logic        [COORD_W-1:0]    a_height;
        logic signed [COORD_W-1:0]    b_pos_x;
        logic signed [COORD_W-1:0]    b_pos_y;
        logic signed [DIR_FRAC+1:0]   b_right_x;
        logic signed [DIR_FRAC+1:0]   b_right_y;
        logic        [COORD_W-1:0]    b_width;
        logic        [COORD_W-1:0]    b_height;
    } t_pair;

    typedef struct {
        t_pair p;
        int    flag;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    orso_pair_if #(.COORD_WIDTH(COORD_W), .DIR_FRAC_BITS(DIR_FRAC)) pair_bus ();
    orso_res_if res_bus ();

    oriented_rect_overlap_sat #(
        .COORD_WIDTH   (COORD_W),
        .DIR_FRAC_BITS (DIR_FRAC)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pair  (pair_bus),
        .o_res   (res_bus)
    );

    bit       want_overlap_q [$];
    t_dir_row rows [$];
    bit       offer_flag;
    bit       quiet;
    bit       hold_req;
    int       n_mismatch;

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic bit predict_overlap(input t_pair p);
        longint            ux [4];
        longint            uy [4];
        longint unsigned   ext [4];
        longint            dx;
        longint            dy;
        longint            d;
        longint unsigned   extent;
        longint unsigned   reach;
        bit                ov;
        ux[0] = longint'($signed(p.a_right_x));
        uy[0] = longint'($signed(p.a_right_y));
        ux[1] = -uy[0];
        uy[1] = ux[0];
        ux[2] = longint'($signed(p.b_right_x));
        uy[2] = longint'($signed(p.b_right_y));
        ux[3] = -uy[2];
        uy[3] = ux[2];
        ext[0] = 64'(p.a_width);
        ext[1] = 64'(p.a_height);
        ext[2] = 64'(p.b_width);
        ext[3] = 64'(p.b_height);
        dx = longint'($signed(p.a_pos_x)) - longint'($signed(p.b_pos_x));
        dy = longint'($signed(p.a_pos_y)) - longint'($signed(p.b_pos_y));
        ov = 1'b1;
        for (int i = 0; i < 4; i++) begin
            extent = '0;
            for (int j = 0; j < 4; j++) begin
                d = ux[i] * ux[j] + uy[i] * uy[j];
                extent += magnitude(d) * ext[j];
            end
            reach = magnitude(ux[i] * dx + uy[i] * dy) << (DIR_FRAC + 1);
            if (extent < reach) ov = 1'b0;
        end
        return ov;
    endfunction

    function automatic t_dir_row dir_row(input int apx, apy, arx, ary, aw, ah,
                                         input int bpx, bpy, brx, bry, bw, bh, flag);
        t_dir_row r;
        r.p.a_pos_x   = COORD_W'(apx);
        r.p.a_pos_y   = COORD_W'(apy);
        r.p.a_right_x = DIR_W'(arx);
        r.p.a_right_y = DIR_W'(ary);
        r.p.a_width   = COORD_W'(aw);
        r.p.a_height  = COORD_W'(ah);
        r.p.b_pos_x   = COORD_W'(bpx);
        r.p.b_pos_y   = COORD_W'(bpy);
        r.p.b_right_x = DIR_W'(brx);
        r.p.b_right_y = DIR_W'(bry);
        r.p.b_width   = COORD_W'(bw);
        r.p.b_height  = COORD_W'(bh);
        r.flag        = flag;
        return r;
    endfunction

    function automatic void unit_dir(output int x, output int y);
        int cosv [5];
        int sinv [5];
        int k;
        cosv = '{16384, 15137, 11585, 6270, 0};
        sinv = '{0, 6270, 11585, 15137, 16384};
        k = $urandom_range(0, 4);
        x = cosv[k] + int'($urandom_range(0, 2)) - 1;
        y = sinv[k] + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1)) x = -x;
        if ($urandom_range(0, 1)) y = -y;
    endfunction

    function automatic int odd_dir();
        int vals [6];
        vals = '{0, -32768, 32767, 16384, -16384, 1};
        return vals[$urandom_range(0, 5)];
    endfunction

    function automatic logic [COORD_W-1:0] rect_size();
        return ($urandom_range(0, 9) == 0) ? COORD_W'($urandom)
                                           : COORD_W'($urandom_range(0, 8192));
    endfunction

    function automatic t_pair random_pair();
        t_pair p;
        int    mode;
        int    span;
        int    gap;
        int    ax;
        int    ay;
        int    bx;
        int    by;
        mode = $urandom_range(0, 9);
        if (mode == 0)
            return {$urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom};
        unit_dir(ax, ay);
        unit_dir(bx, by);
        if (mode == 2) begin
            if ($urandom_range(0, 1)) ax = odd_dir();
            if ($urandom_range(0, 1)) ay = odd_dir();
            if ($urandom_range(0, 1)) bx = odd_dir();
            if ($urandom_range(0, 1)) by = odd_dir();
        end
        p.a_right_x = DIR_W'(ax);
        p.a_right_y = DIR_W'(ay);
        p.b_right_x = DIR_W'(bx);
        p.b_right_y = DIR_W'(by);
        p.a_width   = rect_size();
        p.a_height  = rect_size();
        p.b_width   = rect_size();
        p.b_height  = rect_size();
        p.a_pos_x   = COORD_W'($urandom);
        p.a_pos_y   = COORD_W'($urandom);
        if (mode == 1) begin
            // axis aligned, centers at the touching distance or one step off
            p.a_right_x  = DIR_W'(16384);
            p.a_right_y  = '0;
            p.b_right_x  = DIR_W'(16384);
            p.b_right_y  = '0;
            p.a_width[0] = 1'b0;
            p.b_width[0] = 1'b0;
            gap = (int'(p.a_width) + int'(p.b_width)) / 2 + int'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1)) gap = -gap;
            p.b_pos_x = COORD_W'(int'(p.a_pos_x) + gap);
            p.b_pos_y = p.a_pos_y;
        end else begin
            span = (int'(p.a_width) + int'(p.a_height) + int'(p.b_width)
                    + int'(p.b_height)) / 2;
            p.b_pos_x = COORD_W'(int'(p.a_pos_x) + int'($urandom_range(0, 2 * span)) - span);
            p.b_pos_y = COORD_W'(int'(p.a_pos_y) + int'($urandom_range(0, 2 * span)) - span);
        end
        return p;
    endfunction

    task automatic send_pair(input t_pair p, input bit flag);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            pair_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        pair_bus.a_pos_x   <= p.a_pos_x;
        pair_bus.a_pos_y   <= p.a_pos_y;
        pair_bus.a_right_x <= p.a_right_x;
        pair_bus.a_right_y <= p.a_right_y;
        pair_bus.a_width   <= p.a_width;
        pair_bus.a_height  <= p.a_height;
        pair_bus.b_pos_x   <= p.b_pos_x;
        pair_bus.b_pos_y   <= p.b_pos_y;
        pair_bus.b_right_x <= p.b_right_x;
        pair_bus.b_right_y <= p.b_right_y;
        pair_bus.b_width   <= p.b_width;
        pair_bus.b_height  <= p.b_height;
        pair_bus.valid     <= 1'b1;
        offer_flag = flag;
        @(posedge i_clk);
        while (!pair_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

    // result side: random stalls, one long hold-off
    initial begin
        bit held;
        held = 1'b0;
        res_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && hold_req && !held) begin
                held = 1'b1;
                res_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (i_rst_n && !quiet && $urandom_range(0, 4) == 0) begin
                res_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
            end
            res_bus.ready <= i_rst_n;
        end
    end

    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n) begin
            if (pair_bus.valid && pair_bus.ready)
                want_overlap_q.push_back(offer_flag);
            if (res_bus.valid && res_bus.ready) begin
                if (want_overlap_q.size() == 0) begin
                    n_mismatch++;
                    $display("%0t: unexpected transfer, expected none actual %0b",
                             $time, res_bus.overlap);
                end else begin
                    want = want_overlap_q.pop_front();
                    if (res_bus.overlap !== want) begin
                        n_mismatch++;
                        $display("%0t: overlap mismatch, expected %0b actual %0b",
                                 $time, want, res_bus.overlap);
                    end
                end
            end
        end
    end

    initial begin
        bit flag;
        pair_bus.valid     = 1'b0;
        pair_bus.a_pos_x   = '0;
        pair_bus.a_pos_y   = '0;
        pair_bus.a_right_x = '0;
        pair_bus.a_right_y = '0;
        pair_bus.a_width   = '0;
        pair_bus.a_height  = '0;
        pair_bus.b_pos_x   = '0;
        pair_bus.b_pos_y   = '0;
        pair_bus.b_right_x = '0;
        pair_bus.b_right_y = '0;
        pair_bus.b_width   = '0;
        pair_bus.b_height  = '0;
        i_rst_n    = 1'b0;
        offer_flag = 1'b0;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        n_mismatch = 0;

        rows.push_back(dir_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        rows.push_back(dir_row(0, 0, 16384, 0, 512, 512, 0, 0, 16384, 0, 512, 512, 1));
        // touching along x, then one step apart
        rows.push_back(dir_row(0, 0, 16384, 0, 512, 512, 512, 0, 16384, 0, 512, 512, 1));
        rows.push_back(dir_row(0, 0, 16384, 0, 512, 512, 513, 0, 16384, 0, 512, 512, 0));
        // touching along the up axis, then one step apart
        rows.push_back(dir_row(0, 0, 16384, 0, 512, 512, 0, -512, 16384, 0, 512, 512, 1));
        rows.push_back(dir_row(0, 0, 16384, 0, 512, 512, 0, -513, 16384, 0, 512, 512, 0));
        rows.push_back(dir_row(-8388608, -8388608, 16384, 0, 0, 0,
                               8388607, 8388607, 16384, 0, 0, 0, 0));
        rows.push_back(dir_row(-8388608, -8388608, 16384, 0, 16777215, 16777215,
                               8388607, 8388607, 16384, 0, 16777215, 16777215, 1));
        // zero axes never separate
        rows.push_back(dir_row(-8388608, 8388607, 0, 0, 16777215, 0,
                               8388607, -8388608, 0, 0, 0, 16777215, 1));
        rows.push_back(dir_row(0, 0, 0, 0, 512, 512, 2000, 0, 16384, 0, 512, 512, 0));
        rows.push_back(dir_row(100, 100, 16384, 0, 0, 0, 100, 100, 0, 16384, 0, 0, 1));
        rows.push_back(dir_row(0, 0, 16384, 0, 0, 0, 1, 0, 16384, 0, 0, 0, 0));
        rows.push_back(dir_row(0, 0, -32768, -32768, 700, 300,
                               900, -400, -32768, -32768, 200, 800, PREDICT));
        rows.push_back(dir_row(0, 0, 32767, 32767, 700, 300,
                               900, -400, 32767, -32768, 200, 800, PREDICT));
        rows.push_back(dir_row(-300, 50, -16384, 16384, 1000, 1000,
                               800, 900, 16384, -16384, 400, 400, PREDICT));
        rows.push_back(dir_row(0, 0, 11585, 11585, 1024, 1024,
                               1400, 0, 16384, 0, 512, 512, PREDICT));
        rows.push_back(dir_row(0, 0, 11585, 11585, 1024, 1024,
                               1100, 0, 16384, 0, 512, 512, PREDICT));
        rows.push_back(dir_row(0, 0, 0, 16384, 256, 4096,
                               1500, 200, 11585, -11585, 768, 768, PREDICT));
        rows.push_back(dir_row(32'hFFFFFF, 32'hFFFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFFFF,
                               32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFF, 32'hFFFF,
                               32'hFFFFFF, 32'hFFFFFF, PREDICT));
        rows.push_back(dir_row(32'hAAAAAA, 32'h555555, 32'hAAAA, 32'h5555, 32'hAAAAAA,
                               32'h555555, 32'h555555, 32'hAAAAAA, 32'h5555, 32'hAAAA,
                               32'h555555, 32'hAAAAAA, PREDICT));
        rows.push_back(dir_row(32'h555555, 32'hAAAAAA, 32'h5555, 32'hAAAA, 32'h555555,
                               32'hAAAAAA, 32'hAAAAAA, 32'h555555, 32'hAAAA, 32'h5555,
                               32'hAAAAAA, 32'h555555, PREDICT));

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) begin
            flag = (rows[k].flag == PREDICT) ? predict_overlap(rows[k].p) : rows[k].flag[0];
            send_pair(rows[k].p, flag);
        end

        for (int k = 0; k < N_RANDOM; k++) begin
            t_pair p;
            p = random_pair();
            if (k == HOLD_AT) hold_req = 1'b1;
            if (k == N_RANDOM - N_QUIET) quiet = 1'b1;
            if (k == PAUSE_AT) begin
                pair_bus.valid <= 1'b0;
                while (want_overlap_q.size() != 0) @(negedge i_clk);
                @(negedge i_clk);
            end
            send_pair(p, predict_overlap(p));
        end

        pair_bus.valid <= 1'b0;
        while (want_overlap_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (n_mismatch == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
sv/orso_pkg.sv
sv/orso_if.sv
sv/orso_dot.sv
sv/orso_ext.sv
sv/orso_cmp.sv
sv/oriented_rect_overlap_sat.sv
tb/sv/tb_oriented_rect_overlap_sat.sv
